/* hw/rtl/ffpra_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffpra_pkg
// Shared widths, codes and the page table command struct.
// ----------------------------------------------------------------------------
package ffpra_pkg;

	localparam int NUM_PAGES_DEF = 1024;

	localparam int OP_W   = 2;
	localparam int ADDR_W = 64;
	localparam int CNT_W  = 11;
	localparam int STAT_W = 2;

	localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_FAIL = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic rd_en;
		logic wr_start;
		logic wr_used;
		logic used_val;
	} table_cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/ffpra_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffpra_table
// Page table storage: start address and used bit per page, one write port,
// one read port with registered read data.
// ----------------------------------------------------------------------------
module ffpra_table import ffpra_pkg::*; #(
	parameter int NUM_PAGES = NUM_PAGES_DEF,
	parameter int AW        = $clog2(NUM_PAGES)
) (
	input  wire logic              clk,
	input  wire table_cmd_t        cmd,
	input  wire logic [AW-1:0]     rd_idx,
	input  wire logic [AW-1:0]     wr_idx,
	input  wire logic [ADDR_W-1:0] wr_start_data,
	output logic      [ADDR_W-1:0] start_rd,
	output logic                   used_rd
);

	logic [ADDR_W-1:0] start_mem [NUM_PAGES];
	logic              used_mem  [NUM_PAGES];

	always_ff @(posedge clk) begin
		if (cmd.wr_start) begin
			start_mem[wr_idx] <= wr_start_data;
		end
		if (cmd.wr_used) begin
			used_mem[wr_idx] <= cmd.used_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			start_rd <= start_mem[rd_idx];
			used_rd  <= used_mem[rd_idx];
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/first_fit_page_run_allocator_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_page_run_allocator_core
// First-fit contiguous page run allocator over a table of page descriptors.
//
// Request channel (req_valid/req_stall): operation, address, page_count.
// Response channel (rsp_valid/rsp_stall): status, run_address; one response
// per request, in order.
// Add, an unused operation code, a zero-length allocate and any request on an
// empty table are answered from idle: the response is valid the cycle after
// the request is taken.
// Allocate and free scan the table one entry per cycle through the single
// table read port (free compares each start address with the request
// address), then on a hit walk the run one entry per cycle through the write port.
// One request is worked at a time; req_stall is high from acceptance until
// the response is loaded into the output register.
// A stalled response holds in the output register; a finished alloc or free
// waits in its final state until that register frees up.
// Reset clears the page count and the control state; the table contents are
// not cleared and need no clearing pass, since only added entries are read.
// ----------------------------------------------------------------------------
module first_fit_page_run_allocator_core import ffpra_pkg::*; #(
	parameter int NUM_PAGES = NUM_PAGES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic [OP_W-1:0]   operation,
	input  wire logic [ADDR_W-1:0] address,
	input  wire logic [CNT_W-1:0]  page_count,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output logic      [STAT_W-1:0] status,
	output logic      [ADDR_W-1:0] run_address
);

	localparam int AW = $clog2(NUM_PAGES);
	localparam int CW = $clog2(NUM_PAGES + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_MARK = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]        state_q, state_d;
	logic [CW-1:0]     pages_added_q, pages_added_d;
	logic              out_vld_q, out_vld_d;
	logic              rd_vld_s1, rd_vld_d;

	logic [OP_W-1:0]   op_q, op_d;
	logic [ADDR_W-1:0] addr_q, addr_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CW-1:0]     issue_idx_q, issue_idx_d;
	logic [CW-1:0]     rd_idx_s1, rd_idx_d;
	logic [CNT_W-1:0]  run_q, run_d;
	logic [CW-1:0]     first_q, first_d;
	logic [ADDR_W-1:0] res_addr_q, res_addr_d;
	logic [STAT_W-1:0] res_status_q, res_status_d;
	logic [CW-1:0]     mark_idx_q, mark_idx_d;
	logic [CNT_W-1:0]  rem_q, rem_d;
	logic              mark_val_q, mark_val_d;
	logic [STAT_W-1:0] status_q, status_d;
	logic [ADDR_W-1:0] run_address_q, run_address_d;

	table_cmd_t        cmd;
	logic [AW-1:0]     tbl_rd_idx;
	logic [AW-1:0]     tbl_wr_idx;
	logic [ADDR_W-1:0] start_rd;
	logic              used_rd;

	logic              can_load;
	logic              accept;
	logic              issue_ok;
	logic              scan_done;
	logic [CW-1:0]     last_idx;
	logic [CNT_W-1:0]  run_inc;
	logic              addr_match;

	ffpra_table #(
		.NUM_PAGES(NUM_PAGES),
		.AW       (AW)
	) u_table (
		.clk          (clk),
		.cmd          (cmd),
		.rd_idx       (tbl_rd_idx),
		.wr_idx       (tbl_wr_idx),
		.wr_start_data(address),
		.start_rd     (start_rd),
		.used_rd      (used_rd)
	);

	assign can_load   = !out_vld_q || !rsp_stall;
	assign req_stall  = (state_q != S_IDLE) || !can_load;
	assign accept     = req_valid && !req_stall;
	assign issue_ok   = issue_idx_q < pages_added_q;
	assign last_idx   = pages_added_q - CW'(1);
	assign run_inc    = run_q + CNT_W'(1);
	assign addr_match = start_rd == addr_q;

	assign rsp_valid   = out_vld_q;
	assign status      = status_q;
	assign run_address = run_address_q;

	always_comb begin
		state_d       = state_q;
		pages_added_d = pages_added_q;
		out_vld_d     = out_vld_q && rsp_stall;
		rd_vld_d      = 1'b0;
		op_d          = op_q;
		addr_d        = addr_q;
		count_d       = count_q;
		issue_idx_d   = issue_idx_q;
		rd_idx_d      = rd_idx_s1;
		run_d         = run_q;
		first_d       = first_q;
		res_addr_d    = res_addr_q;
		res_status_d  = res_status_q;
		mark_idx_d    = mark_idx_q;
		rem_d         = rem_q;
		mark_val_d    = mark_val_q;
		status_d      = status_q;
		run_address_d = run_address_q;
		cmd           = '0;
		tbl_rd_idx    = issue_idx_q[AW-1:0];
		tbl_wr_idx    = mark_idx_q[AW-1:0];
		scan_done     = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_d          = operation;
					addr_d        = address;
					count_d       = page_count;
					issue_idx_d   = '0;
					run_d         = '0;
					out_vld_d     = 1'b1;
					status_d      = ST_FAIL;
					run_address_d = '0;
					unique case (operation)
						OP_ADD: begin
							if (pages_added_q == CW'(NUM_PAGES)) begin
								status_d = ST_FULL;
							end else begin
								status_d      = ST_OK;
								cmd.wr_start  = 1'b1;
								cmd.wr_used   = 1'b1;
								cmd.used_val  = 1'b0;
								tbl_wr_idx    = pages_added_q[AW-1:0];
								pages_added_d = pages_added_q + CW'(1);
							end
						end
						OP_ALLOC: begin
							if (page_count != '0 && pages_added_q != '0) begin
								out_vld_d = out_vld_q && rsp_stall;
								state_d   = S_SCAN;
							end
						end
						OP_FREE: begin
							if (pages_added_q != '0) begin
								out_vld_d = out_vld_q && rsp_stall;
								state_d   = S_SCAN;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				if (rd_vld_s1) begin
					if (op_q == OP_ALLOC) begin
						if (!used_rd) begin
							run_d = run_inc;
							if (run_q == '0) begin
								first_d    = rd_idx_s1;
								res_addr_d = start_rd;
							end
							if (run_inc == count_q) begin
								scan_done    = 1'b1;
								res_status_d = ST_OK;
								mark_idx_d   = (run_q == '0) ? rd_idx_s1 : first_q;
								rem_d        = count_q;
								mark_val_d   = 1'b1;
								state_d      = S_MARK;
							end
						end else begin
							run_d = '0;
						end
					end else if (addr_match) begin
						scan_done    = 1'b1;
						res_status_d = ST_OK;
						res_addr_d   = '0;
						mark_idx_d   = rd_idx_s1;
						rem_d        = count_q;
						mark_val_d   = 1'b0;
						state_d      = S_MARK;
					end
					if (!scan_done && rd_idx_s1 == last_idx) begin
						scan_done    = 1'b1;
						res_status_d = ST_FAIL;
						res_addr_d   = '0;
						state_d      = S_FIN;
					end
				end
				if (issue_ok && !scan_done) begin
					cmd.rd_en   = 1'b1;
					rd_vld_d    = 1'b1;
					rd_idx_d    = issue_idx_q;
					issue_idx_d = issue_idx_q + CW'(1);
				end
			end
			S_MARK: begin
				if (rem_q == '0 || mark_idx_q == pages_added_q) begin
					state_d = S_FIN;
				end else begin
					cmd.wr_used  = 1'b1;
					cmd.used_val = mark_val_q;
					mark_idx_d   = mark_idx_q + CW'(1);
					rem_d        = rem_q - CNT_W'(1);
				end
			end
			S_FIN: begin
				if (can_load) begin
					out_vld_d     = 1'b1;
					status_d      = res_status_q;
					run_address_d = res_addr_q;
					state_d       = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pages_added_q <= '0;
			out_vld_q     <= 1'b0;
			rd_vld_s1     <= 1'b0;
		end else begin
			state_q       <= state_d;
			pages_added_q <= pages_added_d;
			out_vld_q     <= out_vld_d;
			rd_vld_s1     <= rd_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q          <= op_d;
		addr_q        <= addr_d;
		count_q       <= count_d;
		issue_idx_q   <= issue_idx_d;
		rd_idx_s1     <= rd_idx_d;
		run_q         <= run_d;
		first_q       <= first_d;
		res_addr_q    <= res_addr_d;
		res_status_q  <= res_status_d;
		mark_idx_q    <= mark_idx_d;
		rem_q         <= rem_d;
		mark_val_q    <= mark_val_d;
		status_q      <= status_d;
		run_address_q <= run_address_d;
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pages_added_q <= CW'(NUM_PAGES))
		else $error("page count above table size");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_SCAN) && (rd_idx_s1 < pages_added_q))
		else $error("scan read outside added pages");

	a_mark_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK) |-> (mark_idx_q <= pages_added_q))
		else $error("run walk past table end");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != ST_OK) |-> (run_address == '0))
		else $error("nonzero address on failed item");
`endif

endmodule
`default_nettype wire
